[rtl/lfps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_pkg: shared types and constants of the line-follow PID steering block
// Register indexes, reset values, gain bundle, output limits and queue sizing.
// ----------------------------------------------------------------------------
package lfps_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int GAIN_W      = 32;
	localparam int ISUM_W      = 32;
	localparam int COUNT_W     = 16;
	localparam int TURN_W      = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LIGHT_THRESHOLD = 3'd0,
		REG_CLEAR_LIMIT     = 3'd1,
		REG_GAIN_P          = 3'd2,
		REG_GAIN_I          = 3'd3,
		REG_GAIN_D          = 3'd4
	} lfps_reg_t;

	localparam int                 THRESHOLD_RESET   = 600;
	localparam logic [COUNT_W-1:0] CLEAR_LIMIT_RESET = 16'd250;
	localparam logic [GAIN_W-1:0]  GAIN_P_RESET      = 32'd25165824;
	localparam logic [GAIN_W-1:0]  GAIN_I_RESET      = 32'd16777;
	localparam logic [GAIN_W-1:0]  GAIN_D_RESET      = 32'd1677721600;

	localparam logic signed [TURN_W-1:0] TURN_MAX = 8'sd100;
	localparam logic signed [TURN_W-1:0] TURN_MIN = -8'sd100;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_i;
		logic [GAIN_W-1:0] gain_d;
	} lfps_gains_t;

endpackage

[rtl/lfps_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_front: error and integral front end
// Forms the error per sample, runs the tick counter and the saturating
// trapezoidal integral, and hands error, difference and sum to the queue.
// ----------------------------------------------------------------------------
module lfps_front #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [SAMPLE_BITS-1:0] light_level,
	input  logic [SAMPLE_BITS-1:0] light_threshold,
	input  logic [15:0]            clear_limit,
	output logic signed [SAMPLE_BITS:0]   err,
	output logic signed [SAMPLE_BITS+1:0] diff,
	output logic signed [31:0]            isum
);
	import lfps_pkg::*;

	localparam int EW = SAMPLE_BITS + 1;
	localparam int DW = SAMPLE_BITS + 2;
	localparam int AW = ISUM_W + 2;

	logic signed [EW-1:0]     prev_error_q;
	logic signed [ISUM_W-1:0] integral_q;
	logic [COUNT_W-1:0]       tick_q;

	logic [COUNT_W:0]         tick_next;
	logic                     clear;
	logic signed [ISUM_W-1:0] base;
	logic signed [AW-1:0]     acc;

	always_comb begin
		err       = $signed({1'b0, light_level}) - $signed({1'b0, light_threshold});
		diff      = DW'(err) - DW'(prev_error_q);
		tick_next = {1'b0, tick_q} + (COUNT_W+1)'(1);
		clear     = tick_next > {1'b0, clear_limit};
		base      = clear ? '0 : integral_q;
		acc       = AW'(base) + AW'(err) + AW'(prev_error_q);
		// saturate to the signed 32-bit range
		if (!acc[AW-1] && (acc[AW-2:ISUM_W-1] != '0)) begin
			isum = {1'b0, {(ISUM_W-1){1'b1}}};
		end else if (acc[AW-1] && (acc[AW-2:ISUM_W-1] != '1)) begin
			isum = {1'b1, {(ISUM_W-1){1'b0}}};
		end else begin
			isum = acc[ISUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
			integral_q   <= '0;
			tick_q       <= '0;
		end else if (accept) begin
			prev_error_q <= err;
			integral_q   <= isum;
			tick_q       <= clear ? '0 : tick_next[COUNT_W-1:0];
		end
	end

endmodule

[rtl/lfps_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_queue: short FIFO between front end and back end
// Decouples the integral loop from the multiply pipeline.
// ----------------------------------------------------------------------------
module lfps_queue #(
	parameter int WIDTH = 56
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	import lfps_pkg::*;

	logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_pop;

	assign full     = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_pop   = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/lfps_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfps_back: gain multiply, sum, floor and clamp pipeline
// Three stages: products, negated sum, shift and clamp into the result register.
// ----------------------------------------------------------------------------
module lfps_back #(
	parameter int SAMPLE_BITS    = 10,
	parameter int GAIN_FRAC_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS:0]   err,
	input  logic signed [SAMPLE_BITS+1:0] diff,
	input  logic signed [31:0]            isum,
	input  lfps_pkg::lfps_gains_t         gains,
	input  logic                          pop,
	output logic                          empty,
	output logic signed [7:0]             turn_command,
	output logic                          turn_clamped
);
	import lfps_pkg::*;

	localparam int EW  = SAMPLE_BITS + 1;
	localparam int DW  = SAMPLE_BITS + 2;
	localparam int PPW = GAIN_W + 1 + EW;
	localparam int PIW = GAIN_W + 1 + ISUM_W;
	localparam int PDW = GAIN_W + 1 + DW;
	localparam int SW  = PIW + 2;

	logic                  v1_q, v2_q, v3_q;
	logic                  adv1, adv2, adv3;
	logic signed [PPW-1:0] pp_s1;
	logic signed [PIW-1:0] pi_s1;
	logic signed [PDW-1:0] pd_s1;
	logic signed [PPW-1:0] pp_d;
	logic signed [PIW-1:0] pi_d;
	logic signed [PDW-1:0] pd_d;
	logic signed [SW-1:0]  neg_s2;
	logic signed [SW-1:0]  shifted;
	logic signed [7:0]     turn_s3;
	logic                  clamped_s3;

	assign adv3     = !v3_q || pop;
	assign adv2     = !v2_q || adv3;
	assign adv1     = !v1_q || adv2;
	assign in_ready = adv1;
	assign empty    = !v3_q;

	assign pp_d    = $signed({1'b0, gains.gain_p}) * err;
	assign pi_d    = $signed({1'b0, gains.gain_i}) * isum;
	assign pd_d    = $signed({1'b0, gains.gain_d}) * diff;
	assign shifted = neg_s2 >>> GAIN_FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (adv1) begin
				v1_q <= in_valid;
			end
			if (adv2) begin
				v2_q <= v1_q;
			end
			if (adv3) begin
				v3_q <= v2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			pp_s1 <= pp_d;
			pi_s1 <= pi_d;
			pd_s1 <= pd_d;
		end
		if (adv2 && v1_q) begin
			neg_s2 <= -(SW'(pp_s1) + SW'(pi_s1) + SW'(pd_s1));
		end
		// arithmetic shift of the negated sum floors toward minus infinity
		if (adv3 && v2_q) begin
			if (shifted > SW'(TURN_MAX)) begin
				turn_s3    <= TURN_MAX;
				clamped_s3 <= 1'b1;
			end else if (shifted < SW'(TURN_MIN)) begin
				turn_s3    <= TURN_MIN;
				clamped_s3 <= 1'b1;
			end else begin
				turn_s3    <= shifted[TURN_W-1:0];
				clamped_s3 <= 1'b0;
			end
		end
	end

	assign turn_command = turn_s3;
	assign turn_clamped = clamped_s3;

endmodule

[rtl/line_follow_pid_steering_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_pid_steering_top: PID steering controller for line following
// One light sample in, one clamped steering command out.
// ----------------------------------------------------------------------------
// Input: push a light sample while full is low; one sample per cycle is taken.
// Output: while empty is low, turn_command and turn_clamped show the oldest
// result; pop takes it. Every sample yields exactly one result, in order.
// Path: a pushed sample passes the queue, then the multiply stage, the sum
// stage and the clamp/result register before it appears at the output.
// Throughput: one sample per cycle while pop keeps up, set by the integral update
// in the front end and the fully pipelined three-stage back end.
// When pop stays low, the back stages fill, then the four-entry queue, and
// full rises; nothing is dropped.
// Configuration: write cfg_index/cfg_data with cfg_valid (cfg_ready is always
// high) while no samples are in flight. Indexes 0..4: threshold, clear limit,
// gain_p, gain_i, gain_d; other indexes are ignored.
// Reset (arst_n low): registers return to their defaults, prev error, integral
// sum and tick count clear, queue and pipeline empty.
// ----------------------------------------------------------------------------
module line_follow_pid_steering_top #(
	parameter int GAIN_FRAC_BITS = 24,
	parameter int SAMPLE_BITS    = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [SAMPLE_BITS-1:0]             light_level,
	output logic                               empty,
	input  logic                               pop,
	output logic signed [7:0]                  turn_command,
	output logic                               turn_clamped,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lfps_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lfps_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lfps_pkg::*;

	localparam int EW = SAMPLE_BITS + 1;
	localparam int DW = SAMPLE_BITS + 2;
	localparam int QW = DW + EW + ISUM_W;

	logic [SAMPLE_BITS-1:0] threshold_q;
	logic [COUNT_W-1:0]     clear_limit_q;
	lfps_gains_t            gains_q;

	logic                 accept;
	logic signed [EW-1:0] f_err;
	logic signed [DW-1:0] f_diff;
	logic signed [31:0]   f_isum;
	logic                 q_valid;
	logic                 q_ready;
	logic [QW-1:0]        q_data;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= SAMPLE_BITS'(THRESHOLD_RESET);
			clear_limit_q  <= CLEAR_LIMIT_RESET;
			gains_q.gain_p <= GAIN_P_RESET;
			gains_q.gain_i <= GAIN_I_RESET;
			gains_q.gain_d <= GAIN_D_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LIGHT_THRESHOLD: threshold_q    <= cfg_data[SAMPLE_BITS-1:0];
				REG_CLEAR_LIMIT:     clear_limit_q  <= cfg_data[COUNT_W-1:0];
				REG_GAIN_P:          gains_q.gain_p <= cfg_data;
				REG_GAIN_I:          gains_q.gain_i <= cfg_data;
				REG_GAIN_D:          gains_q.gain_d <= cfg_data;
				default:             ;
			endcase
		end
	end

	lfps_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.light_level    (light_level),
		.light_threshold(threshold_q),
		.clear_limit    (clear_limit_q),
		.err            (f_err),
		.diff           (f_diff),
		.isum           (f_isum)
	);

	lfps_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept),
		.wr_data ({f_diff, f_err, f_isum}),
		.full    (full),
		.rd_valid(q_valid),
		.rd_ready(q_ready),
		.rd_data (q_data)
	);

	lfps_back #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (q_valid),
		.in_ready    (q_ready),
		.err         ($signed(q_data[ISUM_W +: EW])),
		.diff        ($signed(q_data[ISUM_W+EW +: DW])),
		.isum        ($signed(q_data[ISUM_W-1:0])),
		.gains       (gains_q),
		.pop         (pop),
		.empty       (empty),
		.turn_command(turn_command),
		.turn_clamped(turn_clamped)
	);

	a_turn_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (turn_command <= TURN_MAX) && (turn_command >= TURN_MIN))
		else $error("steering command outside limits");

	a_clamp_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && turn_clamped) |-> (turn_command == TURN_MAX) || (turn_command == TURN_MIN))
		else $error("clamp flag set on a command below the limit");

	a_full_blocks_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop && !empty) |=> full)
		else $error("queue drained while the result side was stalled");

endmodule

[tb/line_follow_pid_steering_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_pid_steering_checker: scoreboard for the PID steering block
// Mirrors the configuration registers and the controller state, predicts the
// steering result of every accepted light sample and compares each popped
// result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module line_follow_pid_steering_checker #(
	parameter int GAIN_FRAC_BITS = 24,
	parameter int SAMPLE_BITS    = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic                             full,
	input  logic [SAMPLE_BITS-1:0]           light_level,
	input  logic                             empty,
	input  logic                             pop,
	input  logic signed [7:0]                turn_command,
	input  logic                             turn_clamped,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [lfps_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lfps_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               mismatch_count,
	output int                               turns_pending
);
	import lfps_pkg::*;

	localparam int REPORT_MAX = 10;
	localparam int WIDE_W     = 80;

	typedef struct packed {
		logic signed [TURN_W-1:0] turn;
		logic                     clamped;
	} steer_t;

	steer_t turn_expected_q[$];
	steer_t oldest_turn;

	logic [SAMPLE_BITS-1:0]        threshold_r;
	logic [COUNT_W-1:0]            clear_limit_r;
	logic [GAIN_W-1:0]             gain_p_r;
	logic [GAIN_W-1:0]             gain_i_r;
	logic [GAIN_W-1:0]             gain_d_r;
	logic signed [SAMPLE_BITS+1:0] prev_err_r;
	logic signed [ISUM_W-1:0]      isum_r;
	logic [COUNT_W-1:0]            tick_r;

	// Advance the controller state by one sample and return its steering result.
	function automatic steer_t predict_turn(input logic [SAMPLE_BITS-1:0] light);
		logic signed [SAMPLE_BITS+1:0] err;
		logic signed [ISUM_W+1:0]      acc;
		logic signed [WIDE_W-1:0]      gp, gi, gd, e_w, i_w, d_w, neg_sum, turn_full;
		steer_t                        res;
		err = $signed({2'b00, light}) - $signed({2'b00, threshold_r});
		if (32'(tick_r) + 1 > 32'(clear_limit_r)) begin
			isum_r = '0;
			tick_r = '0;
		end else begin
			tick_r = tick_r + 1'b1;
		end
		acc = isum_r + err + prev_err_r;
		// saturate when the top three bits disagree
		if (acc[ISUM_W+1:ISUM_W-1] != {3{acc[ISUM_W+1]}})
			isum_r = acc[ISUM_W+1] ? {1'b1, {(ISUM_W-1){1'b0}}} : {1'b0, {(ISUM_W-1){1'b1}}};
		else
			isum_r = acc[ISUM_W-1:0];
		gp = {{(WIDE_W-GAIN_W){1'b0}}, gain_p_r};
		gi = {{(WIDE_W-GAIN_W){1'b0}}, gain_i_r};
		gd = {{(WIDE_W-GAIN_W){1'b0}}, gain_d_r};
		e_w = err;
		i_w = isum_r;
		d_w = err - prev_err_r;
		neg_sum = -(gp * e_w + gi * i_w + gd * d_w);
		// arithmetic shift floors toward minus infinity
		turn_full = neg_sum >>> GAIN_FRAC_BITS;
		res.clamped = 1'b0;
		if (turn_full > 100) begin
			res.turn = TURN_MAX;
			res.clamped = 1'b1;
		end else if (turn_full < -100) begin
			res.turn = TURN_MIN;
			res.clamped = 1'b1;
		end else begin
			res.turn = turn_full[TURN_W-1:0];
		end
		prev_err_r = err;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_r = THRESHOLD_RESET[SAMPLE_BITS-1:0];
			clear_limit_r = CLEAR_LIMIT_RESET;
			gain_p_r = GAIN_P_RESET;
			gain_i_r = GAIN_I_RESET;
			gain_d_r = GAIN_D_RESET;
			prev_err_r = '0;
			isum_r = '0;
			tick_r = '0;
			turn_expected_q.delete();
			mismatch_count = 0;
			turns_pending = 0;
		end else begin
			if (pop && !empty) begin
				if (turn_expected_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("%0t: unexpected result turn_command=%0d turn_clamped=%0b",
							$realtime, turn_command, turn_clamped);
				end else begin
					oldest_turn = turn_expected_q.pop_front();
					if (turn_command !== oldest_turn.turn ||
						turn_clamped !== oldest_turn.clamped) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX)
							$display("%0t: mismatch turn_command exp %0d got %0d, turn_clamped exp %0b got %0b",
								$realtime, oldest_turn.turn, turn_command,
								oldest_turn.clamped, turn_clamped);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_LIGHT_THRESHOLD: threshold_r = cfg_data[SAMPLE_BITS-1:0];
					REG_CLEAR_LIMIT:     clear_limit_r = cfg_data[COUNT_W-1:0];
					REG_GAIN_P:          gain_p_r = cfg_data[GAIN_W-1:0];
					REG_GAIN_I:          gain_i_r = cfg_data[GAIN_W-1:0];
					REG_GAIN_D:          gain_d_r = cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (push && !full)
				turn_expected_q.push_back(predict_turn(light_level));
			turns_pending = turn_expected_q.size();
		end
	end

endmodule

[tb/line_follow_pid_steering_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_pid_steering_top_tb: stimulus and verdict for the steering block
// Drives light samples and register writes with random gaps on both queue
// sides; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module line_follow_pid_steering_top_tb;
	import lfps_pkg::*;

	localparam int SAMPLE_BITS    = 10;
	localparam int GAIN_FRAC_BITS = 24;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int LIGHT_MAX      = (1 << SAMPLE_BITS) - 1;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 75;
	localparam int LONG_ITEMS     = 40;
	// 100.5 in Q8.24
	localparam logic [GAIN_W-1:0] GAIN_100P5 = 32'd1686110208;

	logic                    clk;
	logic                    arst_n;
	logic                    push;
	logic                    full;
	logic [SAMPLE_BITS-1:0]  light_level;
	logic                    empty;
	logic                    pop;
	logic signed [7:0]       turn_command;
	logic                    turn_clamped;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_INDEX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	int                      mismatch_count;
	int                      turns_pending;
	int                      cycle_count;
	logic                    no_idle;
	int                      threshold_now;

	line_follow_pid_steering_top #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .light_level(light_level),
		.empty(empty), .pop(pop), .turn_command(turn_command), .turn_clamped(turn_clamped),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	line_follow_pid_steering_checker #(
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) checker_i (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .light_level(light_level),
		.empty(empty), .pop(pop), .turn_command(turn_command), .turn_clamped(turn_clamped),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatch_count(mismatch_count), .turns_pending(turns_pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: random stall before each pop transaction.
	initial begin
		int stall;
		pop = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				pop = 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop = 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			@(negedge clk);
		end
	end

	task automatic send_sample(input int light);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push = 1'b1;
		light_level = light[SAMPLE_BITS-1:0];
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == REG_LIGHT_THRESHOLD)
			threshold_now = int'(data[SAMPLE_BITS-1:0]);
	endtask

	// Drop push, drain every result, then let the pipeline settle.
	task automatic drain();
		push = 1'b0;
		wait (turns_pending == 0);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return $urandom >> $urandom_range(4, 16);
		endcase
	endfunction

	function automatic int pick_light(input int thr);
		int v;
		case ($urandom_range(0, 5))
			0: v = 0;
			1: v = LIGHT_MAX;
			2, 3: v = thr + $urandom_range(0, 8) - 4;
			default: v = $urandom_range(0, LIGHT_MAX);
		endcase
		if (v < 0) v = 0;
		if (v > LIGHT_MAX) v = LIGHT_MAX;
		return v;
	endfunction

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		light_level = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycle_count = 0;
		no_idle = 1'b0;
		threshold_now = THRESHOLD_RESET;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: extremes, zero error and a sharp derivative swing
		send_sample(0);
		send_sample(LIGHT_MAX);
		send_sample(600);
		send_sample(601);
		send_sample(599);
		send_sample(0);
		send_sample(LIGHT_MAX);
		send_sample(LIGHT_MAX);
		send_sample(512);
		drain();

		// fractional sum: 100.5 floors to 100 unflagged, -100.5 floors and clamps
		write_reg(REG_LIGHT_THRESHOLD, 32'd600);
		write_reg(REG_GAIN_P, GAIN_100P5);
		write_reg(REG_GAIN_I, '0);
		write_reg(REG_GAIN_D, '0);
		send_sample(599);
		send_sample(601);
		send_sample(598);
		send_sample(600);
		drain();

		// all gains at maximum, integral cleared every tick
		write_reg(REG_LIGHT_THRESHOLD, '0);
		write_reg(REG_CLEAR_LIMIT, '0);
		write_reg(REG_GAIN_P, '1);
		write_reg(REG_GAIN_I, '1);
		write_reg(REG_GAIN_D, '1);
		send_sample(LIGHT_MAX);
		send_sample(0);
		send_sample(LIGHT_MAX);
		send_sample(1);
		drain();

		// wide writes: upper bits must be masked off; unused indexes ignored
		write_reg(REG_LIGHT_THRESHOLD, 32'hFFFF_FC00 | 32'd300);
		write_reg(REG_CLEAR_LIMIT, 32'hABCD_0003);
		write_reg(REG_GAIN_P, GAIN_P_RESET);
		write_reg(REG_GAIN_I, GAIN_I_RESET);
		write_reg(REG_GAIN_D, GAIN_D_RESET);
		write_reg(CFG_INDEX_W'(REG_GAIN_D) + CFG_INDEX_W'(1), '1);
		write_reg(CFG_INDEX_W'(REG_GAIN_D) + CFG_INDEX_W'(3), $urandom);
		send_sample(300);
		send_sample(299);
		send_sample(301);
		send_sample(LIGHT_MAX);
		send_sample(0);
		drain();

		// clear limit at its maximum: the integral keeps growing, back to back
		write_reg(REG_LIGHT_THRESHOLD, '0);
		write_reg(REG_CLEAR_LIMIT, 32'h0000_FFFF);
		write_reg(REG_GAIN_P, '0);
		write_reg(REG_GAIN_I, 32'd1);
		write_reg(REG_GAIN_D, '0);
		no_idle = 1'b1;
		repeat (LONG_ITEMS) send_sample(LIGHT_MAX - $urandom_range(0, 15));
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			no_idle = 1'b0;
			case ($urandom_range(0, 3))
				0: write_reg(REG_LIGHT_THRESHOLD, '0);
				1: write_reg(REG_LIGHT_THRESHOLD, CFG_DATA_W'(LIGHT_MAX));
				2: write_reg(REG_LIGHT_THRESHOLD, CFG_DATA_W'($urandom_range(500, 700)));
				default: write_reg(REG_LIGHT_THRESHOLD, $urandom);
			endcase
			case ($urandom_range(0, 3))
				0: write_reg(REG_CLEAR_LIMIT, '0);
				1: write_reg(REG_CLEAR_LIMIT, 32'h0000_FFFF);
				2: write_reg(REG_CLEAR_LIMIT, CFG_DATA_W'($urandom_range(1, 20)));
				default: write_reg(REG_CLEAR_LIMIT, $urandom);
			endcase
			write_reg(REG_GAIN_P, pick_gain());
			write_reg(REG_GAIN_I, pick_gain());
			write_reg(REG_GAIN_D, pick_gain());
			if ($urandom_range(0, 2) == 0)
				write_reg(CFG_INDEX_W'(REG_GAIN_D) + CFG_INDEX_W'($urandom_range(1, 3)), $urandom);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 16 == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				send_sample(pick_light(threshold_now));
			end
			drain();
		end

		no_idle = 1'b0;
		push = 1'b0;
		wait (turns_pending == 0);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[line_follow_pid_steering_top.f]
rtl/lfps_pkg.sv
rtl/lfps_front.sv
rtl/lfps_queue.sv
rtl/lfps_back.sv
rtl/line_follow_pid_steering_top.sv
tb/line_follow_pid_steering_checker.sv
tb/line_follow_pid_steering_top_tb.sv
